// ----- hdl/iqpu_pkg.sv -----
// Shared types, constants and helper functions of the I/Q phase unwrapper.
package iqpu_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int PT_W        = SAMPLE_BITS + 1;
   localparam int SUM_W       = 10;
   localparam int ABS_W       = 9;
   localparam int VALUE_W     = 14;
   localparam int IDX_W       = 4;
   localparam int TGT_W       = 13;
   localparam int WLEN_W      = 9;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_W       = 13;

   typedef logic [SAMPLE_BITS-1:0]      sample_type;
   typedef logic signed [PT_W-1:0]      point_type;
   typedef logic signed [SUM_W-1:0]     sum_type;
   typedef logic [ABS_W-1:0]            abs_type;
   typedef logic signed [VALUE_W-1:0]   value_type;
   typedef logic signed [1:0]           delta_type;

   localparam sum_type   SUM_HI      = {1'b0, {(SUM_W-1){1'b1}}};
   localparam sum_type   SUM_LO      = {1'b1, {(SUM_W-1){1'b0}}};
   localparam abs_type   ABS_HI      = {ABS_W{1'b1}};
   localparam point_type OFFSET_INIT = point_type'(1 << (SAMPLE_BITS - 1));

   localparam logic KIND_PHASE = 1'b0;
   localparam logic KIND_STAT  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_MEDIAN_I = 3'd0,
      CFG_MEDIAN_Q = 3'd1,
      CFG_NOISE    = 3'd2,
      CFG_STRONG   = 3'd3,
      CFG_TARGET   = 3'd4,
      CFG_WLEN     = 3'd5
   } cfg_idx_type;

   typedef enum logic [IDX_W-1:0] {
      ST_TOTAL      = 4'd0,
      ST_ABS_TOTAL  = 4'd1,
      ST_ABS_ZERO   = 4'd2,
      ST_ABS_STRONG = 4'd3,
      ST_HALF1      = 4'd4,
      ST_HALF2      = 4'd5,
      ST_ABS_ALL    = 4'd6,
      ST_ABS_H1     = 4'd7,
      ST_ABS_H2     = 4'd8,
      ST_RANGE_ALL  = 4'd9,
      ST_RANGE_H1   = 4'd10,
      ST_RANGE_H2   = 4'd11,
      ST_OFF_I      = 4'd12,
      ST_OFF_Q      = 4'd13,
      ST_COUNT      = 4'd14
   } stat_idx_type;

   typedef struct packed {
      delta_type d_main;
      delta_type d_zero;
      delta_type d_strong;
      point_type vi;
      point_type vq;
      logic      over;
   } win_upd_type;

   typedef struct packed {
      logic upd;
      logic clr;
   } win_ctl_type;

   // +1 on a negative-to-positive I crossing, -1 on positive-to-negative.
   function automatic delta_type cross_delta(point_type pi, point_type pq,
                                             point_type vi, point_type vq);
      logic signed [2*PT_W-1:0] p1;
      logic signed [2*PT_W-1:0] p2;
      logic signed [2*PT_W:0]   c;
      p1 = pq * vi;
      p2 = pi * vq;
      c  = {p1[2*PT_W-1], p1} - {p2[2*PT_W-1], p2};
      if (c < 0 && pi < 0 && vi > 0)
         return 2'sb01;
      else if (c > 0 && pi > 0 && vi < 0)
         return 2'sb11;
      return 2'sb00;
   endfunction

   function automatic sum_type sat_sum(sum_type a, delta_type d);
      if (a == SUM_HI && d > 0)
         return SUM_HI;
      if (a == SUM_LO && d < 0)
         return SUM_LO;
      return a + SUM_W'(d);
   endfunction

   function automatic abs_type sat_abs(abs_type a, logic inc);
      if (inc && a != ABS_HI)
         return a + ABS_W'(1);
      return a;
   endfunction

   function automatic logic [SUM_W-1:0] abs_sum(sum_type a);
      return (a < 0) ? SUM_W'(-a) : SUM_W'(a);
   endfunction

   function automatic logic [PT_W-1:0] abs_pt(point_type a);
      return (a < 0) ? PT_W'(-a) : PT_W'(a);
   endfunction

   function automatic logic [PT_W-1:0] pick_offset(point_type mx, point_type mn);
      logic signed [PT_W:0] up;
      logic signed [PT_W:0] dn;
      up = {mx[PT_W-1], mx} - {OFFSET_INIT[PT_W-1], OFFSET_INIT};
      dn = {OFFSET_INIT[PT_W-1], OFFSET_INIT} - {mn[PT_W-1], mn};
      return (up > dn) ? abs_pt(mx) : abs_pt(mn);
   endfunction

endpackage

// ----- hdl/iqpu_if.sv -----
// Valid/ready channel interfaces for sample words and result words.
interface iqpu_req_if import iqpu_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_i;
   sample_type sample_q;
   logic       window_end;

   modport source (output valid, output sample_i, output sample_q, output window_end,
                   input ready);
   modport sink   (input valid, input sample_i, input sample_q, input window_end,
                   output ready);
endinterface

interface iqpu_rsp_if import iqpu_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             kind;
   logic [IDX_W-1:0] stat_index;
   value_type        value;
   logic             last_result;

   modport source (output valid, output kind, output stat_index, output value,
                   output last_result, input ready);
   modport sink   (input valid, input kind, input stat_index, input value,
                   input last_result, output ready);
endinterface

// ----- hdl/iqpu_window.sv -----
// Window statistics: unwrap sums, displacements, ranges, offsets and count.
module iqpu_window import iqpu_pkg::*; #(
   parameter int MAX_WINDOW = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  win_ctl_type        ctl,
   input  win_upd_type        upd,
   input  logic [WLEN_W-1:0]  window_length,
   input  stat_idx_type       stat_sel,
   output sum_type            phase,
   output value_type          stat_value
);

   localparam int SIDX_W = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
   localparam int CMP_W  = (SIDX_W > WLEN_W - 1) ? SIDX_W : WLEN_W - 1;
   localparam logic [SIDX_W-1:0] SIDX_LAST = SIDX_W'(MAX_WINDOW - 1);

   sum_type           main_ff, main_in;
   sum_type           zero_ff, zero_in;
   sum_type           strong_ff, strong_in;
   sum_type           half_ff [2];
   sum_type           half_in [2];
   abs_type           absd_ff [3];
   abs_type           absd_in [3];
   sum_type           mn_ff [3];
   sum_type           mn_in [3];
   sum_type           mx_ff [3];
   sum_type           mx_in [3];
   point_type         off_ff [4];
   point_type         off_in [4];
   abs_type           cnt_ff, cnt_in;
   logic [SIDX_W-1:0] sidx_ff, sidx_in;

   logic    first_half;
   logic    moved;
   sum_type s_new;

   assign phase      = sat_sum(main_ff, upd.d_main);
   assign s_new      = phase;
   assign moved      = (upd.d_main != 2'sb00);
   assign first_half = CMP_W'(sidx_ff) < CMP_W'(window_length[WLEN_W-1:1]);

   always_comb begin
      main_in   = main_ff;
      zero_in   = zero_ff;
      strong_in = strong_ff;
      half_in   = half_ff;
      absd_in   = absd_ff;
      mn_in     = mn_ff;
      mx_in     = mx_ff;
      off_in    = off_ff;
      cnt_in    = cnt_ff;
      sidx_in   = sidx_ff;
      if (ctl.clr) begin
         main_in   = '0;
         zero_in   = '0;
         strong_in = '0;
         half_in   = '{default: '0};
         absd_in   = '{default: '0};
         mn_in     = '{default: '0};
         mx_in     = '{default: '0};
         off_in    = '{default: OFFSET_INIT};
         cnt_in    = '0;
         sidx_in   = '0;
      end else if (ctl.upd) begin
         main_in   = s_new;
         zero_in   = sat_sum(zero_ff, upd.d_zero);
         strong_in = sat_sum(strong_ff, upd.d_strong);
         absd_in[0] = sat_abs(absd_ff[0], moved);
         mn_in[0]   = (s_new < mn_ff[0]) ? s_new : mn_ff[0];
         mx_in[0]   = (s_new > mx_ff[0]) ? s_new : mx_ff[0];
         if (first_half) begin
            half_in[0] = sat_sum(half_ff[0], upd.d_main);
            absd_in[1] = sat_abs(absd_ff[1], moved);
            mn_in[1]   = (s_new < mn_ff[1]) ? s_new : mn_ff[1];
            mx_in[1]   = (s_new > mx_ff[1]) ? s_new : mx_ff[1];
         end else begin
            half_in[1] = sat_sum(half_ff[1], upd.d_main);
            absd_in[2] = sat_abs(absd_ff[2], moved);
            mn_in[2]   = (s_new < mn_ff[2]) ? s_new : mn_ff[2];
            mx_in[2]   = (s_new > mx_ff[2]) ? s_new : mx_ff[2];
         end
         if (upd.vi > off_ff[0]) off_in[0] = upd.vi;
         if (upd.vi < off_ff[1]) off_in[1] = upd.vi;
         if (upd.vq > off_ff[2]) off_in[2] = upd.vq;
         if (upd.vq < off_ff[3]) off_in[3] = upd.vq;
         cnt_in = sat_abs(cnt_ff, upd.over);
         if (sidx_ff != SIDX_LAST)
            sidx_in = sidx_ff + SIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff   <= '0;
         zero_ff   <= '0;
         strong_ff <= '0;
         half_ff   <= '{default: '0};
         absd_ff   <= '{default: '0};
         mn_ff     <= '{default: '0};
         mx_ff     <= '{default: '0};
         off_ff    <= '{default: OFFSET_INIT};
         cnt_ff    <= '0;
         sidx_ff   <= '0;
      end else begin
         main_ff   <= main_in;
         zero_ff   <= zero_in;
         strong_ff <= strong_in;
         half_ff   <= half_in;
         absd_ff   <= absd_in;
         mn_ff     <= mn_in;
         mx_ff     <= mx_in;
         off_ff    <= off_in;
         cnt_ff    <= cnt_in;
         sidx_ff   <= sidx_in;
      end
   end

   always_comb begin
      case (stat_sel)
         ST_TOTAL:      stat_value = value_type'(main_ff);
         ST_ABS_TOTAL:  stat_value = value_type'(abs_sum(main_ff));
         ST_ABS_ZERO:   stat_value = value_type'(abs_sum(zero_ff));
         ST_ABS_STRONG: stat_value = value_type'(abs_sum(strong_ff));
         ST_HALF1:      stat_value = value_type'(half_ff[0]);
         ST_HALF2:      stat_value = value_type'(half_ff[1]);
         ST_ABS_ALL:    stat_value = value_type'(absd_ff[0]);
         ST_ABS_H1:     stat_value = value_type'(absd_ff[1]);
         ST_ABS_H2:     stat_value = value_type'(absd_ff[2]);
         ST_RANGE_ALL:  stat_value = value_type'(mx_ff[0]) - value_type'(mn_ff[0]);
         ST_RANGE_H1:   stat_value = value_type'(mx_ff[1]) - value_type'(mn_ff[1]);
         ST_RANGE_H2:   stat_value = value_type'(mx_ff[2]) - value_type'(mn_ff[2]);
         ST_OFF_I:      stat_value = value_type'(pick_offset(off_ff[0], off_ff[1]));
         ST_OFF_Q:      stat_value = value_type'(pick_offset(off_ff[2], off_ff[3]));
         ST_COUNT:      stat_value = value_type'(cnt_ff);
         default:       stat_value = '0;
      endcase
   end

endmodule

// ----- hdl/iq_phase_unwrap_window_stats_top.sv -----
// I/Q cross-product phase unwrapper with per-window statistics, top level.
// Takes one sample word per clock while neither the result side nor a statistics
// burst holds the pipeline, and returns one phase word per sample through the input
// register, median subtract and gating, three cross-product trackers and the result
// register. A sample marked window_end is followed by fifteen statistic words, one
// per clock while the receiver is ready, read out of the window registers; the
// pipeline holds during that burst, after which the window sums are cleared. Tracker
// points carry over between windows. Signed sums saturate at -512 and +511, absolute
// sums and counts at 511 if no end mark arrives.
module iq_phase_unwrap_window_stats_top import iqpu_pkg::*; #(
   parameter int MAX_WINDOW = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   iqpu_req_if.sink             req_bus,
   iqpu_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // configuration
   sample_type         med_i_ff, med_q_ff, noise_ff, strong_ff;
   logic [TGT_W-1:0]   target_ff;
   logic [WLEN_W-1:0]  wlen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         med_i_ff  <= sample_type'(OFFSET_INIT);
         med_q_ff  <= sample_type'(OFFSET_INIT);
         noise_ff  <= '0;
         strong_ff <= '0;
         target_ff <= '0;
         wlen_ff   <= WLEN_W'(250);
      end else if (csr_we) begin
         case (cfg_idx_type'(csr_index))
            CFG_MEDIAN_I: med_i_ff  <= csr_wdata[SAMPLE_BITS-1:0];
            CFG_MEDIAN_Q: med_q_ff  <= csr_wdata[SAMPLE_BITS-1:0];
            CFG_NOISE:    noise_ff  <= csr_wdata[SAMPLE_BITS-1:0];
            CFG_STRONG:   strong_ff <= csr_wdata[SAMPLE_BITS-1:0];
            CFG_TARGET:   target_ff <= csr_wdata[TGT_W-1:0];
            CFG_WLEN:     wlen_ff   <= csr_wdata[WLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline handshake
   logic v0_ff, v1_ff, v2_ff;
   logic ready0, ready1, ready2;
   logic acc, adv1, adv2, consume2;
   logic load_en;
   logic burst_ff;
   stat_idx_type burst_idx_ff;
   logic burst_last;

   assign load_en    = !rsp_bus.valid || rsp_bus.ready;
   assign burst_last = (burst_idx_ff == ST_COUNT);
   assign consume2   = load_en && !burst_ff && v2_ff;
   assign ready2     = !v2_ff || consume2;
   assign adv2       = v1_ff && ready2;
   assign ready1     = !v1_ff || ready2;
   assign adv1       = v0_ff && ready1;
   assign ready0     = !v0_ff || ready1;
   assign acc        = req_bus.valid && ready0;
   assign req_bus.ready = ready0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (acc)       v0_ff <= 1'b1;
         else if (adv1) v0_ff <= 1'b0;
         if (adv1)      v1_ff <= 1'b1;
         else if (adv2) v1_ff <= 1'b0;
         if (adv2)          v2_ff <= 1'b1;
         else if (consume2) v2_ff <= 1'b0;
      end
   end

   // stage 0: input register
   sample_type p0_i_ff, p0_q_ff;
   logic       p0_end_ff;

   always_ff @(posedge clock) begin
      if (acc) begin
         p0_i_ff   <= req_bus.sample_i;
         p0_q_ff   <= req_bus.sample_q;
         p0_end_ff <= req_bus.window_end;
      end
   end

   // stage 1: median removal, gates, tracker point hand-off
   point_type            vi, vq;
   logic [PT_W-1:0]      ai, aq;
   logic signed [PT_W:0] iq_sum;
   logic [PT_W-1:0]      iq_mag;
   logic                 gate_main, gate_strong, over;

   assign vi = point_type'({1'b0, p0_i_ff}) - point_type'({1'b0, med_i_ff});
   assign vq = point_type'({1'b0, p0_q_ff}) - point_type'({1'b0, med_q_ff});
   assign ai = abs_pt(vi);
   assign aq = abs_pt(vq);
   assign iq_sum = {vi[PT_W-1], vi} + {vq[PT_W-1], vq};
   assign iq_mag = (iq_sum < 0) ? PT_W'(-iq_sum) : PT_W'(iq_sum);
   assign over   = TGT_W'(iq_mag) > target_ff;
   assign gate_main   = (ai > PT_W'(noise_ff)) || (aq > PT_W'(noise_ff));
   assign gate_strong = (ai > PT_W'(strong_ff)) || (aq > PT_W'(strong_ff));

   point_type pm_i_ff, pm_q_ff, pz_i_ff, pz_q_ff, ps_i_ff, ps_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_i_ff <= '0;
         pm_q_ff <= '0;
         pz_i_ff <= '0;
         pz_q_ff <= '0;
         ps_i_ff <= '0;
         ps_q_ff <= '0;
      end else if (adv1) begin
         if (gate_main) begin
            pm_i_ff <= vi;
            pm_q_ff <= vq;
         end
         pz_i_ff <= vi;
         pz_q_ff <= vq;
         if (gate_strong) begin
            ps_i_ff <= vi;
            ps_q_ff <= vq;
         end
      end
   end

   point_type p1_vi_ff, p1_vq_ff;
   point_type p1_mi_ff, p1_mq_ff, p1_zi_ff, p1_zq_ff, p1_si_ff, p1_sq_ff;
   logic      p1_gm_ff, p1_gs_ff, p1_over_ff, p1_end_ff;

   always_ff @(posedge clock) begin
      if (adv1) begin
         p1_vi_ff   <= vi;
         p1_vq_ff   <= vq;
         p1_mi_ff   <= pm_i_ff;
         p1_mq_ff   <= pm_q_ff;
         p1_zi_ff   <= pz_i_ff;
         p1_zq_ff   <= pz_q_ff;
         p1_si_ff   <= ps_i_ff;
         p1_sq_ff   <= ps_q_ff;
         p1_gm_ff   <= gate_main;
         p1_gs_ff   <= gate_strong;
         p1_over_ff <= over;
         p1_end_ff  <= p0_end_ff;
      end
   end

   // stage 2: cross products of the three trackers
   win_upd_type p2_upd_ff;
   logic        p2_end_ff;

   always_ff @(posedge clock) begin
      if (adv2) begin
         p2_upd_ff.d_main   <= p1_gm_ff ?
                               cross_delta(p1_mi_ff, p1_mq_ff, p1_vi_ff, p1_vq_ff) : 2'sb00;
         p2_upd_ff.d_zero   <= cross_delta(p1_zi_ff, p1_zq_ff, p1_vi_ff, p1_vq_ff);
         p2_upd_ff.d_strong <= p1_gs_ff ?
                               cross_delta(p1_si_ff, p1_sq_ff, p1_vi_ff, p1_vq_ff) : 2'sb00;
         p2_upd_ff.vi       <= p1_vi_ff;
         p2_upd_ff.vq       <= p1_vq_ff;
         p2_upd_ff.over     <= p1_over_ff;
         p2_end_ff          <= p1_end_ff;
      end
   end

   // window statistics
   win_ctl_type win_ctl;
   sum_type     phase;
   value_type   stat_value;

   assign win_ctl.upd = consume2;
   assign win_ctl.clr = load_en && burst_ff && burst_last;

   iqpu_window #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .ctl           (win_ctl),
      .upd           (p2_upd_ff),
      .window_length (wlen_ff),
      .stat_sel      (burst_idx_ff),
      .phase         (phase),
      .stat_value    (stat_value)
   );

   // result register and statistics burst
   logic             out_valid_ff;
   logic             out_kind_ff;
   logic [IDX_W-1:0] out_idx_ff;
   value_type        out_value_ff;
   logic             out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         burst_ff     <= 1'b0;
         burst_idx_ff <= ST_TOTAL;
      end else if (load_en) begin
         if (burst_ff) begin
            out_valid_ff <= 1'b1;
            if (burst_last)
               burst_ff <= 1'b0;
            else
               burst_idx_ff <= stat_idx_type'(burst_idx_ff + IDX_W'(1));
         end else if (v2_ff) begin
            out_valid_ff <= 1'b1;
            if (p2_end_ff) begin
               burst_ff     <= 1'b1;
               burst_idx_ff <= ST_TOTAL;
            end
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         if (burst_ff) begin
            out_kind_ff  <= KIND_STAT;
            out_idx_ff   <= burst_idx_ff;
            out_value_ff <= stat_value;
            out_last_ff  <= burst_last;
         end else begin
            out_kind_ff  <= KIND_PHASE;
            out_idx_ff   <= ST_TOTAL;
            out_value_ff <= value_type'(phase);
            out_last_ff  <= !p2_end_ff;
         end
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.kind        = out_kind_ff;
   assign rsp_bus.stat_index  = out_idx_ff;
   assign rsp_bus.value       = out_value_ff;
   assign rsp_bus.last_result = out_last_ff;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for the I/Q phase unwrapper: directed and random sample words checked against a predictor.
module tb_top;
   import iqpu_pkg::*;

   localparam int MAX_WINDOW = 256;
   localparam int FULL_SCALE = 4095;
   localparam int TRK_MAIN   = 0;
   localparam int TRK_ZERO   = 1;
   localparam int TRK_STRONG = 2;

   typedef struct packed {
      sample_type si;
      sample_type sq;
      logic       wend;
   } sample_word_type;

   typedef struct packed {
      logic             kind;
      logic [IDX_W-1:0] stat_index;
      value_type        value;
      logic             last_result;
   } result_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   iqpu_req_if req_if ();
   iqpu_rsp_if rsp_if ();

   iq_phase_unwrap_window_stats_top #(.MAX_WINDOW(MAX_WINDOW)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   sample_word_type sample_backlog[$];
   result_word_type due_words[$];
   sample_word_type next_word;
   logic            req_taken = 1'b0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   int              errors = 0;
   int              n_samples = 0;
   int              n_windows = 0;
   int              n_words = 0;
   int              n_settings = 0;

   // register shadows
   sample_type        cfg_med_i, cfg_med_q, cfg_noise, cfg_strong;
   logic [TGT_W-1:0]  cfg_target;
   logic [WLEN_W-1:0] cfg_wlen;

   // predictor state
   point_type         trk_i[3];
   point_type         trk_q[3];
   sum_type           main_sum, zero_sum, strong_sum;
   sum_type           half_d[2];
   abs_type           abs_d[3];
   sum_type           min_d[3];
   sum_type           max_d[3];
   point_type         ext[4];     // max I, min I, max Q, min Q
   abs_type           over_cnt;
   logic [WLEN_W-1:0] win_idx;

   function automatic int clip(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int magnitude(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int crossing(int t, int vi, int vq);
      longint c;
      int     pi, pq, r;
      pi = int'(trk_i[t]);
      pq = int'(trk_q[t]);
      c  = longint'(pq) * vi - longint'(pi) * vq;
      r  = 0;
      if (c < 0 && pi < 0 && vi > 0)
         r = 1;
      else if (c > 0 && pi > 0 && vi < 0)
         r = -1;
      trk_i[t] = point_type'(vi);
      trk_q[t] = point_type'(vq);
      return r;
   endfunction

   function automatic int choose_offset(int mx, int mn);
      if ((mx - int'(OFFSET_INIT)) > (int'(OFFSET_INIT) - mn))
         return magnitude(mx);
      return magnitude(mn);
   endfunction

   function automatic void clear_window();
      main_sum   = '0;
      zero_sum   = '0;
      strong_sum = '0;
      for (int k = 0; k < 3; k++) begin
         abs_d[k] = '0;
         min_d[k] = '0;
         max_d[k] = '0;
         if (k < 2)
            half_d[k] = '0;
      end
      for (int k = 0; k < 4; k++)
         ext[k] = OFFSET_INIT;
      over_cnt = '0;
      win_idx  = '0;
   endfunction

   task automatic expect_word(logic k, int idx, int v, logic last);
      result_word_type w;
      w.kind        = k;
      w.stat_index  = IDX_W'(idx);
      w.value       = value_type'(v);
      w.last_result = last;
      due_words.push_back(w);
   endtask

   task automatic unwrap_sample(sample_word_type w);
      int vi, vq, ai, aq, d, r, s, h;
      int st[15];
      vi = int'(w.si) - int'(cfg_med_i);
      vq = int'(w.sq) - int'(cfg_med_q);
      ai = magnitude(vi);
      aq = magnitude(vq);
      if (vi > int'(ext[0])) ext[0] = point_type'(vi);
      if (vi < int'(ext[1])) ext[1] = point_type'(vi);
      if (vq > int'(ext[2])) ext[2] = point_type'(vq);
      if (vq < int'(ext[3])) ext[3] = point_type'(vq);
      if (magnitude(vi + vq) > int'(cfg_target))
         over_cnt = abs_type'(clip(int'(over_cnt) + 1, 0, int'(ABS_HI)));
      d = 0;
      if (ai > int'(cfg_noise) || aq > int'(cfg_noise)) begin
         d = crossing(TRK_MAIN, vi, vq);
         main_sum = sum_type'(clip(int'(main_sum) + d, int'(SUM_LO), int'(SUM_HI)));
      end
      r = crossing(TRK_ZERO, vi, vq);
      zero_sum = sum_type'(clip(int'(zero_sum) + r, int'(SUM_LO), int'(SUM_HI)));
      if (ai > int'(cfg_strong) || aq > int'(cfg_strong)) begin
         r = crossing(TRK_STRONG, vi, vq);
         strong_sum = sum_type'(clip(int'(strong_sum) + r, int'(SUM_LO), int'(SUM_HI)));
      end
      h = (int'(win_idx) < int'(cfg_wlen >> 1)) ? 1 : 2;
      s = int'(main_sum);
      half_d[h-1] = sum_type'(clip(int'(half_d[h-1]) + d, int'(SUM_LO), int'(SUM_HI)));
      abs_d[h] = abs_type'(clip(int'(abs_d[h]) + magnitude(d), 0, int'(ABS_HI)));
      abs_d[0] = abs_type'(clip(int'(abs_d[0]) + magnitude(d), 0, int'(ABS_HI)));
      for (int k = 0; k < 3; k += (k == 0) ? h : 3) begin
         if (s < int'(min_d[k])) min_d[k] = sum_type'(s);
         if (s > int'(max_d[k])) max_d[k] = sum_type'(s);
      end
      if (int'(win_idx) < MAX_WINDOW - 1)
         win_idx = win_idx + 1'b1;
      expect_word(KIND_PHASE, 0, s, !w.wend);
      if (w.wend) begin
         st[ST_TOTAL]      = s;
         st[ST_ABS_TOTAL]  = magnitude(s);
         st[ST_ABS_ZERO]   = magnitude(int'(zero_sum));
         st[ST_ABS_STRONG] = magnitude(int'(strong_sum));
         st[ST_HALF1]      = int'(half_d[0]);
         st[ST_HALF2]      = int'(half_d[1]);
         st[ST_ABS_ALL]    = int'(abs_d[0]);
         st[ST_ABS_H1]     = int'(abs_d[1]);
         st[ST_ABS_H2]     = int'(abs_d[2]);
         st[ST_RANGE_ALL]  = int'(max_d[0]) - int'(min_d[0]);
         st[ST_RANGE_H1]   = int'(max_d[1]) - int'(min_d[1]);
         st[ST_RANGE_H2]   = int'(max_d[2]) - int'(min_d[2]);
         st[ST_OFF_I]      = choose_offset(int'(ext[0]), int'(ext[1]));
         st[ST_OFF_Q]      = choose_offset(int'(ext[2]), int'(ext[3]));
         st[ST_COUNT]      = int'(over_cnt);
         for (int n = 0; n < 15; n++)
            expect_word(KIND_STAT, n, st[n], n == ST_COUNT);
         clear_window();
      end
   endtask

   // input word driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_taken || !req_if.valid) begin
         if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_word = sample_backlog.pop_front();
            req_if.valid      <= 1'b1;
            req_if.sample_i   <= next_word.si;
            req_if.sample_q   <= next_word.sq;
            req_if.window_end <= next_word.wend;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock)
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);

   // acceptance, prediction and result checking
   always @(posedge clock) begin
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            unwrap_sample('{req_if.sample_i, req_if.sample_q, req_if.window_end});
            n_samples++;
            if (req_if.window_end)
               n_windows++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            n_words++;
            if (due_words.size() == 0) begin
               $error("result word with nothing expected: kind %0d index %0d value %0d",
                      rsp_if.kind, rsp_if.stat_index, rsp_if.value);
               errors++;
            end else begin
               automatic result_word_type w = due_words.pop_front();
               if (rsp_if.kind !== w.kind) begin
                  $error("kind: expected %0d, got %0d", w.kind, rsp_if.kind);
                  errors++;
               end
               if (rsp_if.stat_index !== w.stat_index) begin
                  $error("stat_index: expected %0d, got %0d", w.stat_index, rsp_if.stat_index);
                  errors++;
               end
               if (rsp_if.value !== w.value) begin
                  $error("value: expected %0d, got %0d", w.value, rsp_if.value);
                  errors++;
               end
               if (rsp_if.last_result !== w.last_result) begin
                  $error("last_result: expected %0d, got %0d", w.last_result,
                         rsp_if.last_result);
                  errors++;
               end
            end
         end
      end
   end

   task automatic write_reg(cfg_idx_type idx, int val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(val);
      case (idx)
         CFG_MEDIAN_I: cfg_med_i  = sample_type'(val);
         CFG_MEDIAN_Q: cfg_med_q  = sample_type'(val);
         CFG_NOISE:    cfg_noise  = sample_type'(val);
         CFG_STRONG:   cfg_strong = sample_type'(val);
         CFG_TARGET:   cfg_target = TGT_W'(val);
         CFG_WLEN:     cfg_wlen   = WLEN_W'(val);
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_mode(int m);
      @(posedge clock);
      case (m)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 66; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 66; end
         default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
   endtask

   task automatic wait_drained();
      while (sample_backlog.size() != 0 || req_if.valid || due_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic add_sample(int i, int q, logic wend);
      sample_word_type w;
      w.si   = sample_type'(clip(i, 0, FULL_SCALE));
      w.sq   = sample_type'(clip(q, 0, FULL_SCALE));
      w.wend = wend;
      sample_backlog.push_back(w);
   endtask

   function automatic int corner_code(int med);
      case ($urandom_range(4))
         0: return 0;
         1: return FULL_SCALE;
         2: return med;
         3: return med + 1;
         default: return med - 1;
      endcase
   endfunction

   // style 0 rotating phasor, 1 full-scale noise, 2 near a gate, 3 corner codes
   task automatic add_window(int n, int style, int mag);
      int q, dir, roll, sx, sy, g, mi, mq;
      mi  = int'(cfg_med_i);
      mq  = int'(cfg_med_q);
      q   = $urandom_range(3);
      dir = $urandom_range(1) ? 1 : -1;
      for (int k = 0; k < n; k++) begin
         case (style)
            0: begin
               roll = $urandom_range(9);
               if (roll < 7)
                  q = (q + dir + 4) % 4;
               else if (roll == 7)
                  q = (q - dir + 4) % 4;
               sx = (q == 0 || q == 3) ? 1 : -1;
               sy = (q < 2) ? 1 : -1;
               add_sample(mi + sx * int'($urandom_range(mag)),
                          mq + sy * int'($urandom_range(mag)), k == n - 1);
            end
            1: add_sample($urandom_range(FULL_SCALE), $urandom_range(FULL_SCALE), k == n - 1);
            2: begin
               g = int'($urandom_range(1) ? cfg_noise : cfg_strong) + 2;
               add_sample(mi + int'($urandom_range(2 * g)) - g,
                          mq + int'($urandom_range(2 * g)) - g, k == n - 1);
            end
            default: add_sample(corner_code(mi), corner_code(mq), k == n - 1);
         endcase
      end
   endtask

   task automatic run_phase(int mi, int mq, int nr, int sr, int tg, int wl,
                            int mode, int items);
      int left, n, pick, style, mag;
      write_reg(CFG_MEDIAN_I, mi);
      write_reg(CFG_MEDIAN_Q, mq);
      write_reg(CFG_NOISE, nr);
      write_reg(CFG_STRONG, sr);
      write_reg(CFG_TARGET, tg);
      write_reg(CFG_WLEN, wl);
      n_settings++;
      set_mode(mode);
      left = items;
      while (left > 0) begin
         pick = $urandom_range(9);
         if (pick < 6)
            n = $urandom_range(1, 12);
         else if (pick < 9)
            n = clip(int'(cfg_wlen) + int'($urandom_range(4)) - 2, 1, 300);
         else
            n = $urandom_range(1, 300);
         if (n > left)
            n = left;
         pick  = $urandom_range(9);
         style = (pick < 6) ? 0 : pick - 6;
         case ($urandom_range(2))
            0: mag = 6;
            1: mag = 150;
            default: mag = 2047;
         endcase
         add_window(n, style, mag);
         left -= n;
      end
      wait_drained();
   endtask

   initial begin
      req_if.valid      = 1'b0;
      req_if.sample_i   = '0;
      req_if.sample_q   = '0;
      req_if.window_end = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CFG_MEDIAN_I;
      csr_wdata         = '0;
      cfg_med_i  = 12'd2048;
      cfg_med_q  = 12'd2048;
      cfg_noise  = '0;
      cfg_strong = '0;
      cfg_target = '0;
      cfg_wlen   = 9'd250;
      for (int t = 0; t < 3; t++) begin
         trk_i[t] = '0;
         trk_q[t] = '0;
      end
      clear_window();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: zero point, crossings both ways, full-scale corners
      set_mode(0);
      add_sample(2048, 2048, 1'b0);
      add_sample(1048, 1048, 1'b0);
      add_sample(3048, 1048, 1'b0);
      add_sample(3048, 3048, 1'b0);
      add_sample(1048, 3048, 1'b0);
      add_sample(1048, 1048, 1'b0);
      add_sample(3048, 1048, 1'b0);
      add_sample(1048, 1048, 1'b0);
      add_sample(0, 0, 1'b0);
      add_sample(4095, 4095, 1'b0);
      add_sample(0, 4095, 1'b0);
      add_sample(4095, 0, 1'b1);
      add_sample(2048, 2049, 1'b1);
      add_sample(4095, 2048, 1'b0);
      add_sample(0, 2048, 1'b0);
      add_sample(2048, 0, 1'b1);
      wait_drained();

      run_phase(2048, 2048, 100, 1000, 2000, 16, 0, 13);
      run_phase(0, 4095, 0, 4095, 8190, 2, 1, 13);
      run_phase(4095, 0, 4095, 0, 0, 256, 2, 13);
      run_phase($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                $urandom_range(4095), $urandom_range(8190),
                2 * $urandom_range(1, 127) + 1, 3, 13);
      run_phase(2000, 2100, 30, 300, 500, 3, 0, 13);
      run_phase($urandom_range(1800, 2300), $urandom_range(1800, 2300),
                $urandom_range(200), $urandom_range(2000), $urandom_range(8190),
                $urandom_range(2, 256), 1, 13);

      // one window long enough to pin the sample index
      run_phase(2048, 2048, 0, 0, 0, 256, 3, 0);
      add_window(262, 0, 2047);
      wait_drained();

      run_phase(1900, 2200, 8, 60, 4000, 7, 3, 13);
      run_phase($urandom_range(4095), $urandom_range(4095), $urandom_range(300),
                $urandom_range(4095), $urandom_range(8190), $urandom_range(2, 256), 2, 13);

      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d samples in %0d windows over %0d register settings",
               n_samples, n_windows, n_settings);
      $display("%0d result words checked, %0d mismatches", n_words, errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- iq_phase_unwrap_window_stats_top.f -----
hdl/iqpu_pkg.sv
hdl/iqpu_if.sv
hdl/iqpu_window.sv
hdl/iq_phase_unwrap_window_stats_top.sv
sim/tb_top.sv
